@@ rtl/tyre_magic_formula_top_assert.svh @@
// Assertion macros shared by the tyre magic formula RTL.
`ifndef TYRE_MAGIC_FORMULA_TOP_ASSERT_SVH
`define TYRE_MAGIC_FORMULA_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TMF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TMF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tmf_pkg.sv @@
// Shared types, constants and elaboration-time CORDIC constant functions.
package tmf_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int B_W        = 23;
  localparam int C_W        = 19;
  localparam int E_W        = 21;
  localparam int MAX_STAGES = 32;
  localparam int ANG_FRAC   = 32;
  localparam int SIN_FRAC   = 30;
  localparam int ANG_W      = 36;
  localparam int BX_W       = 41;

  localparam logic [63:0] BX_LIM = 64'h0000_00FF_FFFF_FFFF;

  localparam logic [B_W-1:0]    B_RST  = 23'd655360;
  localparam logic [C_W-1:0]    C_RST  = 19'd124518;
  localparam logic [DATA_W-1:0] D_RST  = 32'd65536;
  localparam logic [E_W-1:0]    E_RST  = 21'd63570;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS  = 3'd0,
    CFG_SHAPE      = 3'd1,
    CFG_PEAK       = 3'd2,
    CFG_CURVATURE  = 3'd3,
    CFG_HSHIFT     = 3'd4,
    CFG_VSHIFT     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] force_value;
    logic                     saturated;
  } res_t;

  // Shift-subtract division, used only at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q62 by its power series.
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p   = udiv64(64'd1 << 62, n);
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      if (p != 64'd0) begin
        term = udiv64(p, 64'(2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
        p = udiv64(udiv64(p, n), n);
      end
    end
    return sum;
  endfunction

  // atan(2^-i) in Q32 radians, rounded.
  function automatic logic [63:0] cordic_angle(input int i);
    logic [63:0] q;
    if (i == 0) q = atan_recip(64'd2) + atan_recip(64'd3);
    else q = atan_recip(64'd1 << i);
    return (q + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bitv;
    v    = val;
    r    = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 64'd0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return r;
  endfunction

  // Reciprocal CORDIC gain in Q30 for a given stage count.
  function automatic logic [63:0] cordic_inv_gain(input int n);
    logic [63:0] g;
    g = 64'd1 << 60;
    for (int i = 0; i < MAX_STAGES; i++) begin
      if (i < n) g = g + (g >> (2 * i));
    end
    return udiv64(64'd1 << 60, isqrt64(g));
  endfunction

  localparam logic [63:0] ANG0_Q32    = cordic_angle(0);
  localparam logic [63:0] HALF_PI_Q32 = ANG0_Q32 << 1;
  localparam logic [63:0] PI_Q32      = ANG0_Q32 << 2;
  localparam logic [63:0] TWO_PI_Q32  = ANG0_Q32 << 3;

endpackage

@@ rtl/tmf_cordic_stage.sv @@
// One CORDIC micro-rotation with its pipeline register.
module tmf_cordic_stage
  import tmf_pkg::*;
#(
  parameter int XY_W   = 43,
  parameter int SHIFT  = 0,
  parameter bit ROTATE = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [XY_W-1:0]  x_i,
  input  logic signed [XY_W-1:0]  y_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic                    out_valid,
  output logic signed [XY_W-1:0]  x_o,
  output logic signed [XY_W-1:0]  y_o,
  output logic signed [ANG_W-1:0] z_o
);

  localparam logic signed [ANG_W-1:0] ANG = ANG_W'(cordic_angle(SHIFT));

  logic                    valid_r;
  logic signed [XY_W-1:0]  x_r, x_nxt;
  logic signed [XY_W-1:0]  y_r, y_nxt;
  logic signed [ANG_W-1:0] z_r, z_nxt;
  logic signed [XY_W-1:0]  xs, ys;
  logic                    sel;

  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    // vectoring drives y to zero, rotation drives the angle to zero
    if (ROTATE) sel = z_i[ANG_W-1];
    else sel = ~y_i[XY_W-1];
    if (sel) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign out_valid = valid_r;
  assign x_o       = x_r;
  assign y_o       = y_r;
  assign z_o       = z_r;

endmodule

@@ rtl/tmf_cordic.sv @@
// Fully pipelined CORDIC, one register stage per iteration.
module tmf_cordic
  import tmf_pkg::*;
#(
  parameter int XY_W   = 43,
  parameter int STAGES = 24,
  parameter bit ROTATE = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [XY_W-1:0]  x_i,
  input  logic signed [XY_W-1:0]  y_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic                    out_valid,
  output logic signed [XY_W-1:0]  x_o,
  output logic signed [XY_W-1:0]  y_o,
  output logic signed [ANG_W-1:0] z_o
);

  logic                    v_c [STAGES+1];
  logic signed [XY_W-1:0]  x_c [STAGES+1];
  logic signed [XY_W-1:0]  y_c [STAGES+1];
  logic signed [ANG_W-1:0] z_c [STAGES+1];

  assign v_c[0] = in_valid;
  assign x_c[0] = x_i;
  assign y_c[0] = y_i;
  assign z_c[0] = z_i;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    tmf_cordic_stage #(
      .XY_W  (XY_W),
      .SHIFT (i),
      .ROTATE(ROTATE)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v_c[i]),
      .x_i      (x_c[i]),
      .y_i      (y_c[i]),
      .z_i      (z_c[i]),
      .out_valid(v_c[i+1]),
      .x_o      (x_c[i+1]),
      .y_o      (y_c[i+1]),
      .z_o      (z_c[i+1])
    );
  end

  assign out_valid = v_c[STAGES];
  assign x_o       = x_c[STAGES];
  assign y_o       = y_c[STAGES];
  assign z_o       = z_c[STAGES];

endmodule

@@ rtl/tmf_mod2pi.sv @@
// Pipelined reduction of a Q32 angle to [-pi/2, pi/2] for the sine CORDIC.
module tmf_mod2pi
  import tmf_pkg::*;
#(
  parameter int PHI_W = 38,
  parameter int QB    = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [PHI_W-1:0] phi_i,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] r_o
);

  localparam int A_W = 36 + QB;
  localparam logic signed [ANG_W-1:0] TWO_PI  = ANG_W'(TWO_PI_Q32);
  localparam logic signed [ANG_W-1:0] PI      = ANG_W'(PI_Q32);
  localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(HALF_PI_Q32);

  logic             v_c   [QB+1];
  logic [A_W-1:0]   a_c   [QB+1];
  logic             neg_c [QB+1];

  // magnitude stage
  logic                  v0_r, neg0_r;
  logic [A_W-1:0]        a0_r, a0_nxt;
  logic signed [A_W-1:0] phi_ext;

  always_comb begin
    phi_ext = A_W'(phi_i);
    a0_nxt  = phi_i[PHI_W-1] ? A_W'(-phi_ext) : A_W'(phi_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r   <= a0_nxt;
      neg0_r <= phi_i[PHI_W-1];
    end
  end

  assign v_c[0]   = v0_r;
  assign a_c[0]   = a0_r;
  assign neg_c[0] = neg0_r;

  // restoring steps, one quotient bit each, highest multiple first
  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam logic [A_W-1:0] SUB = A_W'(TWO_PI_Q32 << (QB - 1 - j));
    logic           v_r, neg_r;
    logic [A_W-1:0] a_r, a_nxt;

    assign a_nxt = (a_c[j] >= SUB) ? a_c[j] - SUB : a_c[j];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_c[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r   <= a_nxt;
        neg_r <= neg_c[j];
      end
    end

    assign v_c[j+1]   = v_r;
    assign a_c[j+1]   = a_r;
    assign neg_c[j+1] = neg_r;
  end

  // floor residue in [0, 2*pi), then centered in [-pi, pi), then folded
  logic                    vm_r, vc_r, vf_r;
  logic signed [ANG_W-1:0] m_r, m_nxt;
  logic signed [ANG_W-1:0] c_r, c_nxt;
  logic signed [ANG_W-1:0] f_r, f_nxt;
  logic signed [ANG_W-1:0] a_fin;

  always_comb begin
    a_fin = ANG_W'(a_c[QB]);
    m_nxt = (neg_c[QB] && (a_c[QB] != '0)) ? TWO_PI - a_fin : a_fin;
    c_nxt = (m_r >= PI) ? m_r - TWO_PI : m_r;
    if (c_r > HALF_PI) f_nxt = PI - c_r;
    else if (c_r < -HALF_PI) f_nxt = -PI - c_r;
    else f_nxt = c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vc_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      vm_r <= v_c[QB];
      vc_r <= vm_r;
      vf_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
      c_r <= c_nxt;
      f_r <= f_nxt;
    end
  end

  assign out_valid = vf_r;
  assign r_o       = f_r;

endmodule

@@ rtl/tmf_out_skid.sv @@
// Two-entry output buffer that decouples the result channel from the pipeline.
module tmf_out_skid
  import tmf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  res_t       ent0_r, ent0_nxt;
  res_t       ent1_r, ent1_nxt;
  logic       pop;

  assign pop = (cnt_r != 2'd0) && out_ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    if (pop && push_valid) begin
      if (cnt_r == 2'd2) begin
        ent0_nxt = ent1_r;
        ent1_nxt = push_data;
      end else begin
        ent0_nxt = push_data;
      end
    end else if (pop) begin
      ent0_nxt = ent1_r;
      cnt_nxt  = cnt_r - 2'd1;
    end else if (push_valid) begin
      if (cnt_r == 2'd0) ent0_nxt = push_data;
      else ent1_nxt = push_data;
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent0_r;

endmodule

@@ rtl/tyre_magic_formula_top.sv @@
// Top level of the Pacejka magic formula tyre force pipeline.
// One signed Q16.16 slip value in, one saturated Q16.16 force out per
// transaction: force = D*sin(C*atan(Bx - E*(Bx - atan(Bx)))) + Sv, x = slip + Sh.
// The block takes a new transaction every cycle while the output buffer is not
// full. Each of the three unrolled CORDIC pipelines (two arctangents and the
// sine) has depth N = min(CORDIC_STAGES, 32), and the 2*pi range reducer has
// QB = max(19 - FRAC_BITS, 1) restoring steps. A two-entry output buffer keeps
// accepting while one result waits; the whole pipeline holds only when both
// entries are occupied. Coefficients are to be written through the cfg port
// only while the block is idle, which the block itself does not enforce; they
// take effect on the next transaction.
`include "tyre_magic_formula_top_assert.svh"

module tyre_magic_formula_top
  import tmf_pkg::*;
#(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_slip_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_force_value,
  output logic                     out_saturated
);

  localparam int NS    = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  localparam int XY1_W = BX_W + 2;
  // inner = bx - (E*d >> FRAC_BITS) needs room for the wider of its terms
  localparam int INW   = ((63 - FRAC_BITS > BX_W) ? 63 - FRAC_BITS : BX_W) + 1;
  localparam int XY2_W = INW + 2;
  localparam int PHI_W = 54 - FRAC_BITS;
  localparam int QB    = (PHI_W - 35 > 1) ? PHI_W - 35 : 1;
  localparam int XY3_W = 34;

  localparam logic signed [XY1_W-1:0] ONE1  = XY1_W'(64'd1 << FRAC_BITS);
  localparam logic signed [XY2_W-1:0] ONE2  = XY2_W'(64'd1 << FRAC_BITS);
  localparam logic signed [XY3_W-1:0] INV_G = XY3_W'(cordic_inv_gain(NS));
  localparam logic signed [56:0]      BXL   = 57'(BX_LIM);
  localparam logic signed [36:0]      F_HI  = 37'sh0_7FFF_FFFF;
  localparam logic signed [36:0]      F_LO  = -37'sh0_8000_0000;

  // -------------------------------------------------------------------------
  // Coefficient registers
  // -------------------------------------------------------------------------
  logic [B_W-1:0]           b_r;
  logic [C_W-1:0]           c_r;
  logic signed [DATA_W-1:0] d_r;
  logic signed [E_W-1:0]    e_r;
  logic signed [DATA_W-1:0] sh_r;
  logic signed [DATA_W-1:0] sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r  <= B_RST;
      c_r  <= C_RST;
      d_r  <= D_RST;
      e_r  <= E_RST;
      sh_r <= '0;
      sv_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STIFFNESS: b_r  <= cfg_data[B_W-1:0];
        CFG_SHAPE:     c_r  <= cfg_data[C_W-1:0];
        CFG_PEAK:      d_r  <= cfg_data;
        CFG_CURVATURE: e_r  <= cfg_data[E_W-1:0];
        CFG_HSHIFT:    sh_r <= cfg_data;
        CFG_VSHIFT:    sv_r <= cfg_data;
        default: ;     // drop writes to unmapped indexes
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Flow control: every stage advances together unless the output buffer is
  // full. in_ready is register driven, no path from out_ready.
  // -------------------------------------------------------------------------
  logic adv;
  logic skid_full;

  assign adv      = ~skid_full;
  assign in_ready = adv;

  // -------------------------------------------------------------------------
  // Front end: shift, scale by B, clamp
  // -------------------------------------------------------------------------
  logic               v1_r, v2_r, v3_r;
  logic signed [32:0] x1_r, x1_nxt;
  logic signed [56:0] p1_r, p1_nxt;
  logic signed [56:0] p1_sh;
  logic signed [BX_W-1:0] bx_r, bx_nxt;

  always_comb begin
    x1_nxt = 33'(in_slip_value) + 33'(sh_r);
    p1_nxt = $signed({1'b0, b_r}) * x1_r;
    p1_sh  = p1_r >>> FRAC_BITS;
    // clip the scaled argument; not reported on the saturated flag
    if (p1_sh > BXL) bx_nxt = BX_W'(BXL);
    else if (p1_sh < -BXL) bx_nxt = BX_W'(-BXL);
    else bx_nxt = BX_W'(p1_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r <= x1_nxt;
      p1_r <= p1_nxt;
      bx_r <= bx_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // First arctangent: atan(bx), with bx delayed alongside
  // -------------------------------------------------------------------------
  logic                    va1;
  logic signed [ANG_W-1:0] z1;
  logic signed [BX_W-1:0]  bx_dly_r [NS];

  tmf_cordic #(
    .XY_W  (XY1_W),
    .STAGES(NS),
    .ROTATE(1'b0)
  ) u_atan_bx (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v3_r),
    .x_i      (ONE1),
    .y_i      (XY1_W'(bx_r)),
    .z_i      ('0),
    .out_valid(va1),
    .x_o      (),
    .y_o      (),
    .z_o      (z1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      bx_dly_r[0] <= bx_r;
      for (int i = 1; i < NS; i++) begin
        bx_dly_r[i] <= bx_dly_r[i-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Curvature term: inner = bx - E*(bx - atan(bx))
  // -------------------------------------------------------------------------
  logic                    v4_r, v5_r, v6_r;
  logic signed [41:0]      d4_r, d4_nxt;
  logic signed [BX_W-1:0]  bx4_r, bx5_r;
  logic signed [62:0]      p2_r, p2_nxt;
  logic signed [INW-1:0]   in6_r, in6_nxt;

  always_comb begin
    d4_nxt  = 42'(bx_dly_r[NS-1]) - 42'(z1 >>> (ANG_FRAC - FRAC_BITS));
    p2_nxt  = e_r * d4_r;
    in6_nxt = INW'(bx5_r) - INW'(p2_r >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v4_r <= va1;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d4_r  <= d4_nxt;
      bx4_r <= bx_dly_r[NS-1];
      p2_r  <= p2_nxt;
      bx5_r <= bx4_r;
      in6_r <= in6_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Second arctangent and scaling by C
  // -------------------------------------------------------------------------
  logic                    va2;
  logic signed [ANG_W-1:0] z2;
  logic                    v7_r;
  logic signed [55:0]      p3_r, p3_nxt;

  tmf_cordic #(
    .XY_W  (XY2_W),
    .STAGES(NS),
    .ROTATE(1'b0)
  ) u_atan_inner (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v6_r),
    .x_i      (ONE2),
    .y_i      (XY2_W'(in6_r)),
    .z_i      ('0),
    .out_valid(va2),
    .x_o      (),
    .y_o      (),
    .z_o      (z2)
  );

  assign p3_nxt = $signed({1'b0, c_r}) * z2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= va2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r <= p3_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Range reduction and sine
  // -------------------------------------------------------------------------
  logic                    vr;
  logic signed [ANG_W-1:0] r_ang;
  logic                    va3;
  logic signed [XY3_W-1:0] sine;

  tmf_mod2pi #(
    .PHI_W(PHI_W),
    .QB   (QB)
  ) u_mod2pi (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v7_r),
    .phi_i    (PHI_W'(p3_r >>> FRAC_BITS)),
    .out_valid(vr),
    .r_o      (r_ang)
  );

  tmf_cordic #(
    .XY_W  (XY3_W),
    .STAGES(NS),
    .ROTATE(1'b1)
  ) u_sine (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (vr),
    .x_i      (INV_G),
    .y_i      ('0),
    .z_i      (r_ang),
    .out_valid(va3),
    .x_o      (),
    .y_o      (sine),
    .z_o      ()
  );

  // -------------------------------------------------------------------------
  // Peak scaling, vertical shift and saturation into the output buffer
  // -------------------------------------------------------------------------
  logic               v8_r;
  logic signed [65:0] p4_r, p4_nxt;
  logic signed [36:0] f_sum;
  res_t               res;
  res_t               out_res;

  assign p4_nxt = d_r * sine;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (adv) begin
      v8_r <= va3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r <= p4_nxt;
    end
  end

  always_comb begin
    f_sum = 37'(p4_r >>> SIN_FRAC) + 37'(sv_r);
    if (f_sum > F_HI) begin
      res.force_value = DATA_W'(F_HI);
      res.saturated   = 1'b1;
    end else if (f_sum < F_LO) begin
      res.force_value = DATA_W'(F_LO);
      res.saturated   = 1'b1;
    end else begin
      res.force_value = DATA_W'(f_sum);
      res.saturated   = 1'b0;
    end
  end

  tmf_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(v8_r && adv),
    .push_data (res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_force_value = out_res.force_value;
  assign out_saturated   = out_res.saturated;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `TMF_ASSERT_NEXT(a_in_capture, in_valid && in_ready, v1_r, "accepted transaction lost at entry")
  `TMF_ASSERT_NEXT(a_push_shows, adv && v8_r, out_valid, "finished result not presented")
  `TMF_ASSERT_NEXT(a_stall_hold, !adv && v8_r, v8_r && $stable(p4_r), "stalled stage changed")
  `TMF_ASSERT_IMPL(a_stall_cause, !in_ready, out_valid, "input stalled with no result waiting")

endmodule

@@ tb/sv/tyre_magic_formula_top_tb.sv @@
// Self-checking testbench for the magic formula tyre force pipeline.
`timescale 1ns / 100ps

module tyre_magic_formula_top_tb;
  import tmf_pkg::*;

  localparam int FRAC       = 16;
  localparam int STAGES     = 24;
  localparam int HOLD_LONG  = 400;
  localparam int STALL_MAX  = 5000;
  localparam int RAND_ITEMS = 160;
  localparam int PHASES     = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [DATA_W-1:0] slip;
    bit                       typed;   // expected force given in the row
    logic signed [DATA_W-1:0] force_exp;
    logic                     sat_exp;
  } slip_row_t;

  typedef struct {
    logic signed [DATA_W-1:0] force_value;
    logic                     saturated;
  } force_t;

  typedef struct {
    bit     typed;
    force_t val;
  } hint_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_slip_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_force_value;
  logic                     out_saturated;

  // Local copy of the coefficient registers.
  logic [B_W-1:0]           coef_b;
  logic [C_W-1:0]           coef_c;
  logic signed [DATA_W-1:0] coef_d;
  logic signed [E_W-1:0]    coef_e;
  logic signed [DATA_W-1:0] shift_h;
  logic signed [DATA_W-1:0] shift_v;

  longint ang_q32 [MAX_STAGES];
  longint gain_inv_q30;

  force_t pending_forces[$];
  hint_t  row_hints[$];
  int     mismatches = 0;
  int     forces_seen = 0;
  int     sat_seen = 0;
  int     stall_cycles = 0;
  bit     quiet = 1'b0;
  bit     hold_req = 1'b0;

  tyre_magic_formula_top #(
    .FRAC_BITS    (FRAC),
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_slip_value  (in_slip_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_force_value(out_force_value),
    .out_saturated  (out_saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Force predictor: CORDIC constants, arctangent, sine, and the formula.
  // ---------------------------------------------------------------------

  // atan(1/n) in Q62 by the alternating power series.
  function automatic longint unsigned atan_inv_q62(input longint unsigned n);
    longint unsigned p;
    longint unsigned acc;
    longint unsigned k;
    p   = (64'd1 << 62) / n;
    acc = 0;
    k   = 0;
    while (p != 0) begin
      if (k[0]) acc = acc - p / (2 * k + 1);
      else acc = acc + p / (2 * k + 1);
      p = p / n / n;
      k++;
    end
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic build_cordic_tables();
    longint unsigned q;
    longint unsigned g;
    g = 64'd1 << 60;
    for (int i = 0; i < MAX_STAGES; i++) begin
      if (i == 0) q = atan_inv_q62(2) + atan_inv_q62(3);
      else q = atan_inv_q62(64'd1 << i);
      ang_q32[i] = longint'((q + (64'd1 << 29)) >> 30);
    end
    for (int i = 0; i < STAGES && i < MAX_STAGES; i++) g = g + (g >> (2 * i));
    gain_inv_q30 = longint'((64'd1 << 60) / int_sqrt(g));
  endtask

  // Vectoring CORDIC: atan of a Q16 value, Q32 radians.
  function automatic longint atan_q32(input longint v);
    longint xa, ya, za, xs, ys;
    xa = longint'(1) << FRAC;
    ya = v;
    za = 0;
    for (int i = 0; i < STAGES && i < MAX_STAGES; i++) begin
      xs = xa >>> i;
      ys = ya >>> i;
      if (ya >= 0) begin
        xa += ys; ya -= xs; za += ang_q32[i];
      end else begin
        xa -= ys; ya += xs; za -= ang_q32[i];
      end
    end
    return za;
  endfunction

  // Rotation CORDIC: sine of a Q32 angle, Q30 result.
  function automatic longint sin_q30(input longint phi);
    longint pi_q, two_pi_q, half_pi_q, r, xr, yr, xs, ys;
    pi_q      = 4 * ang_q32[0];
    two_pi_q  = 8 * ang_q32[0];
    half_pi_q = 2 * ang_q32[0];
    r  = phi % two_pi_q;
    xr = gain_inv_q30;
    yr = 0;
    if (r < 0) r += two_pi_q;
    if (r >= pi_q) r -= two_pi_q;
    if (r > half_pi_q) r = pi_q - r;
    else if (r < -half_pi_q) r = -pi_q - r;
    for (int i = 0; i < STAGES && i < MAX_STAGES; i++) begin
      xs = xr >>> i;
      ys = yr >>> i;
      if (r >= 0) begin
        xr -= ys; yr += xs; r -= ang_q32[i];
      end else begin
        xr += ys; yr -= xs; r += ang_q32[i];
      end
    end
    return yr;
  endfunction

  function automatic force_t tyre_force(input logic signed [DATA_W-1:0] slip);
    longint bx_lim, xs, bx, at, dlt, inner, phi, s, f;
    force_t res;
    bx_lim = (longint'(1) << 40) - 1;
    xs     = longint'(slip) + longint'(shift_h);
    bx     = (longint'(coef_b) * xs) >>> FRAC;
    if (bx > bx_lim) bx = bx_lim;
    else if (bx < -bx_lim) bx = -bx_lim;
    at    = atan_q32(bx) >>> (ANG_FRAC - FRAC);
    dlt   = bx - at;
    inner = bx - ((longint'(coef_e) * dlt) >>> FRAC);
    phi   = (longint'(coef_c) * atan_q32(inner)) >>> FRAC;
    s     = sin_q30(phi);
    f     = ((longint'(coef_d) * s) >>> SIN_FRAC) + longint'(shift_v);
    res.saturated = 1'b0;
    if (f > longint'(32'sh7FFF_FFFF)) begin
      f = 32'sh7FFF_FFFF; res.saturated = 1'b1;
    end else if (f < -(longint'(1) << 31)) begin
      f = -(longint'(1) << 31); res.saturated = 1'b1;
    end
    res.force_value = f[DATA_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Monitors: predict on input acceptance, check on output acceptance.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    hint_t h;
    if (rst_n && in_valid && in_ready) begin
      h = row_hints.pop_front();
      if (h.typed) pending_forces.insert(pending_forces.size(), h.val);
      else pending_forces.insert(pending_forces.size(), tyre_force(in_slip_value));
    end
  end

  always @(posedge clk) begin
    force_t want;
    if (rst_n && out_valid && out_ready) begin
      forces_seen++;
      if (out_saturated) sat_seen++;
      if (pending_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected force transaction %h sat %b",
                   out_force_value, out_saturated);
      end else begin
        want = pending_forces.pop_front();
        if (out_force_value !== want.force_value || out_saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: force exp %h sat %b, got %h sat %b",
                     want.force_value, want.saturated, out_force_value, out_saturated);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (rst_n) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("ERROR: no progress for %0d cycles", STALL_MAX);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure bursts, one long hold when asked.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        n = HOLD_LONG;
        while (n > 0) begin
          @(posedge clk);
          n--;
        end
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(19, 1)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Offer one slip value; return at the edge where it is accepted.
  task automatic send_slip(input logic signed [DATA_W-1:0] slip, input hint_t h);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    row_hints.insert(row_hints.size(), h);
    in_valid      <= 1'b1;
    in_slip_value <= slip;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every pending force, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write the full coefficient set, plus the two unused indexes.
  task automatic load_coefs(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] c,
                            input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] e,
                            input logic [DATA_W-1:0] sh, input logic [DATA_W-1:0] sv);
    logic [CFG_IDX_W-1:0] idx [8];
    logic [DATA_W-1:0]    val [8];
    idx = '{CFG_STIFFNESS, CFG_SHAPE, CFG_PEAK, CFG_CURVATURE, CFG_HSHIFT, CFG_VSHIFT,
            CFG_SPARE_LO, CFG_SPARE_HI};
    val = '{b, c, d, e, sh, sv, $urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    coef_b  = b[B_W-1:0];
    coef_c  = c[C_W-1:0];
    coef_d  = d;
    coef_e  = e[E_W-1:0];
    shift_h = sh;
    shift_v = sv;
  endtask

  function automatic logic signed [DATA_W-1:0] random_slip();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $signed($urandom_range(8 << FRAC)) - (4 << FRAC);
      2:       return $signed($urandom_range(512)) - 256;
      default: return $signed($urandom_range(64 << FRAC)) - (32 << FRAC);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    slip_row_t rows [$];
    hint_t     h;
    bit        typed_cfg;
    int        sent;

    coef_b  = B_RST;
    coef_c  = C_RST;
    coef_d  = D_RST;
    coef_e  = E_RST;
    shift_h = '0;
    shift_v = '0;
    build_cordic_tables();

    // Reset-default coefficients: extremes of slip, zero and unit points.
    rows = '{
      '{32'sd0, 0, 0, 0}, '{32'sd1, 0, 0, 0}, '{-32'sd1, 0, 0, 0},
      '{32'sh7FFF_FFFF, 0, 0, 0}, '{32'sh8000_0000, 0, 0, 0},
      '{32'sh0001_0000, 0, 0, 0}, '{-32'sh0001_0000, 0, 0, 0},
      '{32'sh0000_8000, 0, 0, 0}, '{32'sh0005_0000, 0, 0, 0},
      '{-32'sh0005_0000, 0, 0, 0}, '{32'sh4000_0000, 0, 0, 0},
      '{32'shC000_0000, 0, 0, 0}, '{32'shAAAA_5555, 0, 0, 0},
      // With zero peak the force is the vertical shift alone.
      '{32'sd0, 1, 32'sh7FFF_FFFF, 0}, '{32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 0},
      '{32'sh8000_0000, 1, 32'sh7FFF_FFFF, 0}, '{32'sh0003_0000, 1, 32'sh7FFF_FFFF, 0},
      '{-32'sh0002_8000, 1, 32'sh7FFF_FFFF, 0}, '{32'sh5555_AAAA, 1, 32'sh7FFF_FFFF, 0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; switch to the zero-peak setting at the first typed row.
    typed_cfg = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].typed && !typed_cfg) begin
        drain();
        load_coefs(32'd655360, 32'd124518, 32'd0, 32'd63570, 32'd0, 32'h7FFF_FFFF);
        typed_cfg = 1'b1;
      end
      h.typed = rows[i].typed;
      h.val.force_value = rows[i].force_exp;
      h.val.saturated   = rows[i].sat_exp;
      send_slip(rows[i].slip, h);
    end
    drain();

    // Random phases; each one loads a new coefficient set first.
    h.typed = 1'b0;
    h.val   = '{default: '0};
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_coefs(32'd655360, 32'd124518, 32'd65536, 32'd63570, 32'd0, 32'd0);
        // Every coefficient at its upper bit extreme, shifts saturating.
        1: load_coefs(32'h007F_FFFF, 32'h0007_FFFF, 32'h7FFF_FFFF, 32'h000F_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // Lower extremes: zero stiffness and shape, most negative values.
        2: load_coefs(32'd0, 32'd0, 32'h8000_0000, 32'h0010_0000,
                      32'h8000_0000, 32'h8000_0000);
        // Stated range limits with large peak so the force clips.
        3: load_coefs(32'd6553600, 32'd262144, 32'h7FFF_FFFF, -32'sd655360,
                      32'd0, 32'h4000_0000);
        4: load_coefs(32'd6553600, 32'd262144, 32'h8000_0000, 32'd65536,
                      32'd0, 32'hC000_0000);
        default: load_coefs($urandom, $urandom, $urandom, $urandom,
                            $urandom_range(1) ? $urandom : $urandom_range(8 << FRAC),
                            $urandom);
      endcase
      // Hold the receiver off for a long stretch so the pipe backs up.
      if (p == 1) hold_req = 1'b1;
      if (p == PHASES - 1) quiet = 1'b1;
      for (sent = 0; sent < RAND_ITEMS; sent++) send_slip(random_slip(), h);
      drain();
    end

    $display("Covered %0d forces (%0d clipped) over %0d coefficient sets,",
             forces_seen, sat_seen, PHASES + 2);
    $display("with random stalls on both channels and one long output hold.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
